>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
    `CHK_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> design/drbm_pkg.sv
package drbm_pkg;

    localparam int DEF_BLOCK_SIZE       = 16;
    localparam int DEF_MAX_GRID_COLUMNS = 128;
    localparam int DEF_MAX_GRID_ROWS    = 128;

    localparam int COORD_W    = 13;
    localparam int QUERY_W    = 14;
    localparam int COUNT_W    = 15;
    localparam int COUNT_MAX  = 32767;
    localparam int GRID_REG_W = 8;
    localparam int DIV_IN_W   = 14;
    localparam int RECIP_W    = 16;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_MARK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [1:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_GRID_COLUMNS,
        REG_GRID_ROWS
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_CLIP,
        ST_PLAN,
        ST_BASE,
        ST_MARK,
        ST_CLEAR,
        ST_READ,
        ST_RDWAIT
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0]    origin_x;
        logic [COORD_W-1:0]    origin_y;
        logic [GRID_REG_W-1:0] grid_columns;
        logic [GRID_REG_W-1:0] grid_rows;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         command;
        logic [COORD_W-1:0] rect_left;
        logic [COORD_W-1:0] rect_top;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [QUERY_W-1:0] query_block;
    } t_in;

    typedef struct packed {
        logic               flag_value;
        logic [COUNT_W-1:0] blocks_set;
    } t_out;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic wr_data;
    } t_mem_ctl;

endpackage

>>> design/damage_rect_block_marker.sv
// channel   | direction | handshake                      | word
// ----------+-----------+--------------------------------+------------------------
// command   | in        | start & !busy                  | i_cmd (t_in)
// result    | out       | o_valid, one cycle, no stall   | o_result (t_out)
// config    | in        | APB psel&penable&pwrite&pready | pwdata at paddr 4*i
//
// Per command: read reads one map block, unknown none, clear writes cols*rows,
// mark writes each covered block (none when clipped away); one map access per cycle.
// After reset, busy sweeps all MAX_GRID_COLUMNS*MAX_GRID_ROWS map blocks clear.
// A new command is taken in the cycle its predecessor's result is strobed.
// Results cannot be held off.
module damage_rect_block_marker
    import drbm_pkg::*;
#(
    parameter int BLOCK_SIZE       = DEF_BLOCK_SIZE,
    parameter int MAX_GRID_COLUMNS = DEF_MAX_GRID_COLUMNS,
    parameter int MAX_GRID_ROWS    = DEF_MAX_GRID_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_cmd,
    output logic                  o_valid,
    output t_out                  o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int MAP_DEPTH = MAX_GRID_COLUMNS * MAX_GRID_ROWS;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    t_cfg              cfg;
    t_mem_ctl          mem_ctl;
    logic [MAP_AW-1:0] mem_addr;
    logic              mem_rdata;

    drbm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    drbm_seq #(
        .BLOCK_SIZE       (BLOCK_SIZE),
        .MAX_GRID_COLUMNS (MAX_GRID_COLUMNS),
        .MAX_GRID_ROWS    (MAX_GRID_ROWS),
        .MAP_AW           (MAP_AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_cfg       (cfg),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .o_mem_ctl   (mem_ctl),
        .o_mem_addr  (mem_addr),
        .i_mem_rdata (mem_rdata)
    );

    drbm_map_ram #(
        .DEPTH (MAP_DEPTH),
        .AW    (MAP_AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .o_rdata (mem_rdata)
    );

endmodule

>>> design/drbm_cfg_regs.sv
module drbm_cfg_regs
    import drbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_hit;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;
    assign wr_hit  = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x     <= '0;
            r_cfg.origin_y     <= '0;
            r_cfg.grid_columns <= GRID_REG_W'(1);
            r_cfg.grid_rows    <= GRID_REG_W'(1);
        end else if (wr_hit) begin
            unique case (reg_idx)
                REG_ORIGIN_X:     r_cfg.origin_x     <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Y:     r_cfg.origin_y     <= pwdata[COORD_W-1:0];
                REG_GRID_COLUMNS: r_cfg.grid_columns <= pwdata[GRID_REG_W-1:0];
                REG_GRID_ROWS:    r_cfg.grid_rows    <= pwdata[GRID_REG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_X:     prdata = APB_DATA_W'(r_cfg.origin_x);
            REG_ORIGIN_Y:     prdata = APB_DATA_W'(r_cfg.origin_y);
            REG_GRID_COLUMNS: prdata = APB_DATA_W'(r_cfg.grid_columns);
            REG_GRID_ROWS:    prdata = APB_DATA_W'(r_cfg.grid_rows);
        endcase
    end

endmodule

>>> design/drbm_map_ram.sv
module drbm_map_ram
    import drbm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_GRID_COLUMNS * DEF_MAX_GRID_ROWS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_addr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

endmodule

>>> design/drbm_seq.sv
module drbm_seq
    import drbm_pkg::*;
#(
    parameter int BLOCK_SIZE       = DEF_BLOCK_SIZE,
    parameter int MAX_GRID_COLUMNS = DEF_MAX_GRID_COLUMNS,
    parameter int MAX_GRID_ROWS    = DEF_MAX_GRID_ROWS,
    parameter int MAP_AW           = (MAX_GRID_COLUMNS * MAX_GRID_ROWS > 1) ?
                                     $clog2(MAX_GRID_COLUMNS * MAX_GRID_ROWS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_in               i_cmd,
    input  t_cfg              i_cfg,
    output logic              o_busy,
    output logic              o_valid,
    output t_out              o_result,
    output t_mem_ctl          o_mem_ctl,
    output logic [MAP_AW-1:0] o_mem_addr,
    input  logic              i_mem_rdata
);

    localparam int MAP_DEPTH  = MAX_GRID_COLUMNS * MAX_GRID_ROWS;
    localparam int CW         = $clog2(MAX_GRID_COLUMNS + 1);
    localparam int RW         = $clog2(MAX_GRID_ROWS + 1);
    localparam int AREA_W     = CW + RW;
    localparam int BASE_W     = COORD_W + CW;
    localparam int SUM_W      = MAP_AW + 1;
    localparam int DIV_SHIFT  = DIV_IN_W + $clog2(BLOCK_SIZE);
    localparam int DIV_RECIP  = ((1 << DIV_SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int DIV_PROD_W = DIV_IN_W + RECIP_W;
    localparam int SPAN_W     = COORD_W + 1;
    localparam int CNT_W      = 2 * SPAN_W;

    t_state              r_state, n_state;
    t_in                 r_cmd;
    t_out                r_out;
    logic                r_valid;
    logic [AREA_W-1:0]   r_addr;
    logic [AREA_W-1:0]   r_area;
    logic [DIV_IN_W-1:0] r_xf, r_xl, r_yf, r_yl;
    logic                r_empty;
    logic [1:0]          r_div_idx;
    logic [COORD_W-1:0]  r_c0, r_c1, r_r0, r_r1;
    logic [COORD_W-1:0]  r_row, r_col;
    logic [COUNT_W-1:0]  r_count;
    logic [MAP_AW-1:0]   r_base;

    logic [CW-1:0]         cols_eff;
    logic [RW-1:0]         rows_eff;
    logic [AREA_W-1:0]     area_prod;
    logic [15:0]           xf, xl, yf, yl;
    logic [DIV_IN_W-1:0]   div_op;
    logic [DIV_PROD_W-1:0] div_prod;
    logic [COORD_W-1:0]    div_q;
    logic                  clip_empty;
    logic [SPAN_W-1:0]     span_c, span_r;
    logic [CNT_W-1:0]      cnt_prod;
    logic [BASE_W-1:0]     base_prod;
    logic [SUM_W-1:0]      mark_sum;
    logic                  mark_last;
    logic                  q_in_range;
    logic                  done;
    t_out                  res_next;

    // grid size clamp
    always_comb begin
        priority if (i_cfg.grid_columns == '0) begin
            cols_eff = CW'(1);
        end else if (32'(i_cfg.grid_columns) > MAX_GRID_COLUMNS) begin
            cols_eff = CW'(MAX_GRID_COLUMNS);
        end else begin
            cols_eff = CW'(i_cfg.grid_columns);
        end
        priority if (i_cfg.grid_rows == '0) begin
            rows_eff = RW'(1);
        end else if (32'(i_cfg.grid_rows) > MAX_GRID_ROWS) begin
            rows_eff = RW'(MAX_GRID_ROWS);
        end else begin
            rows_eff = RW'(i_cfg.grid_rows);
        end
    end

    assign area_prod = AREA_W'(cols_eff) * AREA_W'(rows_eff);

    // first and last pixel relative to origin, two's complement
    assign xf = 16'(r_cmd.rect_left) - 16'(i_cfg.origin_x);
    assign xl = 16'(r_cmd.rect_left) + 16'(r_cmd.rect_width) - 16'd1
              - 16'(i_cfg.origin_x);
    assign yf = 16'(r_cmd.rect_top) - 16'(i_cfg.origin_y);
    assign yl = 16'(r_cmd.rect_top) + 16'(r_cmd.rect_height) - 16'd1
              - 16'(i_cfg.origin_y);

    // divide by block size: reciprocal multiply, exact for 14-bit operands
    always_comb begin
        unique case (r_div_idx)
            2'd0: div_op = r_xf;
            2'd1: div_op = r_xl;
            2'd2: div_op = r_yf;
            2'd3: div_op = r_yl;
        endcase
    end

    assign div_prod = DIV_PROD_W'(div_op) * DIV_PROD_W'(DIV_RECIP);
    assign div_q    = COORD_W'(div_prod >> DIV_SHIFT);

    assign clip_empty = r_empty || (32'(r_c0) >= 32'(cols_eff))
                      || (32'(r_r0) >= 32'(rows_eff));

    assign span_c   = SPAN_W'(r_c1) - SPAN_W'(r_c0) + SPAN_W'(1);
    assign span_r   = SPAN_W'(r_r1) - SPAN_W'(r_r0) + SPAN_W'(1);
    assign cnt_prod = CNT_W'(span_c) * CNT_W'(span_r);

    assign base_prod = BASE_W'(r_r0) * BASE_W'(cols_eff);
    assign mark_sum  = SUM_W'(r_base) + SUM_W'(r_col);
    assign mark_last = (r_col == r_c1) && (r_row == r_r1);

    assign q_in_range = 32'(r_cmd.query_block) < 32'(r_area);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_addr == AREA_W'(MAP_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                priority if (r_cmd.command == CMD_CLEAR) n_state = ST_CLEAR;
                else if (r_cmd.command == CMD_MARK)      n_state = ST_DIV;
                else if (r_cmd.command == CMD_READ)      n_state = ST_READ;
                else                                     n_state = ST_IDLE;
            end
            ST_DIV: begin
                if (r_div_idx == 2'd3) n_state = ST_CLIP;
            end
            ST_CLIP:   n_state = clip_empty ? ST_IDLE : ST_PLAN;
            ST_PLAN:   n_state = ST_BASE;
            ST_BASE:   n_state = ST_MARK;
            ST_MARK: begin
                if (mark_last) n_state = ST_IDLE;
            end
            ST_CLEAR: begin
                if (r_addr == r_area - AREA_W'(1)) n_state = ST_IDLE;
            end
            ST_READ:   n_state = ST_RDWAIT;
            ST_RDWAIT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_mem_ctl  = '0;
        o_mem_addr = '0;
        done       = 1'b0;
        res_next   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_addr      = r_addr[MAP_AW-1:0];
            end
            ST_SETUP: begin
                done = (r_cmd.command != CMD_CLEAR) && (r_cmd.command != CMD_MARK)
                    && (r_cmd.command != CMD_READ);
            end
            ST_CLIP: begin
                done = clip_empty;
            end
            ST_MARK: begin
                o_mem_ctl.wr_en   = 1'b1;
                o_mem_ctl.wr_data = 1'b1;
                o_mem_addr        = mark_sum[MAP_AW-1:0];
                done              = mark_last;
                res_next.blocks_set = r_count;
            end
            ST_CLEAR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_addr      = r_addr[MAP_AW-1:0];
                done            = (r_addr == r_area - AREA_W'(1));
            end
            ST_READ: begin
                o_mem_ctl.rd_en = 1'b1;
                o_mem_addr      = q_in_range ? MAP_AW'(r_cmd.query_block) : '0;
            end
            ST_RDWAIT: begin
                done                = 1'b1;
                res_next.flag_value = q_in_range & i_mem_rdata;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_valid <= 1'b0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= done;
            if (r_state == ST_IDLE) begin
                r_addr <= '0;
            end else if (r_state == ST_INIT || r_state == ST_CLEAR) begin
                r_addr <= r_addr + AREA_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_cmd <= i_cmd;
        end
        if (done) begin
            r_out <= res_next;
        end
        unique case (r_state)
            ST_SETUP: begin
                r_area    <= area_prod;
                r_xf      <= xf[15] ? '0 : xf[DIV_IN_W-1:0];
                r_xl      <= xl[DIV_IN_W-1:0];
                r_yf      <= yf[15] ? '0 : yf[DIV_IN_W-1:0];
                r_yl      <= yl[DIV_IN_W-1:0];
                r_empty   <= (r_cmd.rect_width == '0) || (r_cmd.rect_height == '0)
                          || xl[15] || yl[15];
                r_div_idx <= '0;
            end
            ST_DIV: begin
                unique case (r_div_idx)
                    2'd0: r_c0 <= div_q;
                    2'd1: r_c1 <= div_q;
                    2'd2: r_r0 <= div_q;
                    2'd3: r_r1 <= div_q;
                endcase
                r_div_idx <= r_div_idx + 2'd1;
            end
            ST_CLIP: begin
                if (32'(r_c1) >= 32'(cols_eff)) r_c1 <= COORD_W'(cols_eff - CW'(1));
                if (32'(r_r1) >= 32'(rows_eff)) r_r1 <= COORD_W'(rows_eff - RW'(1));
            end
            ST_PLAN: begin
                r_count <= (cnt_prod > CNT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                          : cnt_prod[COUNT_W-1:0];
            end
            ST_BASE: begin
                r_base <= base_prod[MAP_AW-1:0];
                r_row  <= r_r0;
                r_col  <= r_c0;
            end
            ST_MARK: begin
                if (r_col == r_c1) begin
                    r_col  <= r_c0;
                    r_row  <= r_row + COORD_W'(1);
                    r_base <= r_base + MAP_AW'(cols_eff);
                end else begin
                    r_col <= r_col + COORD_W'(1);
                end
            end
            default: begin
                r_div_idx <= r_div_idx;
            end
        endcase
    end

endmodule

>>> design/drbm_checker.sv
`include "assert_macros.svh"

module drbm_checker
    import drbm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_out o_result
);

    `CHK_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "not busy after accept")
    `CHK_ASSERT(a_done_idle, i_clk, i_rst_n, o_valid |-> !busy, "result while busy")
    `CHK_ASSERT(a_single_strobe, i_clk, i_rst_n, o_valid |=> !o_valid, "result strobe too long")
    `CHK_NEVER(a_flag_count, i_clk, i_rst_n, o_valid && o_result.flag_value && (o_result.blocks_set != '0), "flag and count both set")

endmodule

bind damage_rect_block_marker drbm_checker u_chk (.*);
